// ----- design/fld_pkg.sv -----
// Package for the fixed-length packet deframer.
// Holds configuration reset values, register indexes and the shared structs.
// No dependencies.
`default_nettype none

package fld_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgStartByte  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEndByte    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPacketSize = 2'd2;

  localparam logic [ByteW-1:0] StartReset = 8'h3E;
  localparam logic [ByteW-1:0] EndReset   = 8'h3F;
  localparam logic [ByteW-1:0] SizeReset  = 8'd16;
  localparam logic [ByteW-1:0] MinSize    = 8'd3;

  // Decoded configuration as the framing logic uses it.
  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] end_byte;
    logic [ByteW-1:0] last_pos;
    logic [ByteW-1:0] chk_pos;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    logic [ByteW-1:0] byte_index;
    logic             last;
    logic             packet_good;
  } res_t;

  typedef struct packed {
    logic             in_packet;
    logic [ByteW-1:0] byte_count;
  } status_t;

endpackage

`default_nettype wire

// ----- design/fixed_length_packet_deframer_unit.sv -----
// Fixed-length packet deframer with start byte, additive checksum and end byte.
//
// Usage: received bytes enter on the in_valid_i/in_ready_o channel, one beat per
// byte. While hunting, bytes other than the start byte are dropped silently.
// From the start byte on, packet_size bytes (at least three) are passed out on the
// out_valid_o/out_ready_i channel with their index; the last one carries
// last_o and the packet verdict in packet_good_o.
// An accepted input beat passes the input register, then the result register,
// before its result beat is offered. Throughput is one byte per cycle as long
// as the sink keeps out_ready_i high.
// When the sink stalls, the result register holds its beat and the input
// register fills; in_ready_o drops only when both are full.
// Reset puts the block into hunting with empty registers and restores the
// configuration defaults: start byte 0x3E, end byte 0x3F, 16-byte packets.
// Configuration writes through cfg_we_i take effect at once and are meant to
// happen while no byte is in flight.
// Depends on fld_pkg, fld_cfg, fld_core and fld_out.
`default_nettype none

module fixed_length_packet_deframer_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [fld_pkg::ByteW-1:0]   rx_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [fld_pkg::ByteW-1:0]        byte_out_o,
  output logic [fld_pkg::ByteW-1:0]        byte_index_o,
  output logic                             last_o,
  output logic                             packet_good_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [fld_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fld_pkg::ByteW-1:0]   cfg_data_i
);

  fld_pkg::cfg_t             cfg;
  fld_pkg::res_t             core_res;
  fld_pkg::res_t             out_res;
  fld_pkg::status_t          status;
  logic                      core_res_valid;
  logic                      out_space;
  logic                      advance;
  logic                      in_valid_q;
  logic [fld_pkg::ByteW-1:0] in_byte_q;

  // A byte in the input register is processed once the result register has room.
  assign advance    = in_valid_q && out_space;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  fld_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (core_res_valid),
    .res_o       (core_res),
    .status_o    (status)
  );

  fld_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && core_res_valid),
    .res_i       (core_res),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign byte_out_o    = out_res.byte_out;
  assign byte_index_o  = out_res.byte_index;
  assign last_o        = out_res.last;
  assign packet_good_o = out_res.packet_good;

  // A good verdict only comes with the last byte of a packet.
  a_good_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_good_o |-> last_o)
    else $error("packet_good without last");

  // The shortest packet is three bytes, so the last byte sits at index two or more.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> byte_index_o >= 8'd2)
    else $error("last byte at index below two");

  // While hunting, the byte counter rests at zero.
  a_hunt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.in_packet |-> status.byte_count == '0)
    else $error("byte count nonzero while hunting");

  // A start byte accepted while hunting opens a packet at the next edge.
  a_open_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !status.in_packet && core_res_valid |=> status.in_packet)
    else $error("start byte did not open a packet");

endmodule

`default_nettype wire

// ----- design/fld_cfg.sv -----
// Configuration registers of the packet deframer.
// Depends on fld_pkg; decodes packet size into last and checksum positions.
`default_nettype none

module fld_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [fld_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fld_pkg::ByteW-1:0]   cfg_data_i,
  output fld_pkg::cfg_t                    cfg_o
);

  logic [fld_pkg::ByteW-1:0] start_q;
  logic [fld_pkg::ByteW-1:0] end_q;
  logic [fld_pkg::ByteW-1:0] size_q;
  logic [fld_pkg::ByteW-1:0] eff_size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= fld_pkg::StartReset;
      end_q   <= fld_pkg::EndReset;
      size_q  <= fld_pkg::SizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fld_pkg::CfgStartByte:  start_q <= cfg_data_i;
        fld_pkg::CfgEndByte:    end_q   <= cfg_data_i;
        fld_pkg::CfgPacketSize: size_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sizes below the minimum behave as the minimum packet.
  assign eff_size = (size_q < fld_pkg::MinSize) ? fld_pkg::MinSize : size_q;

  assign cfg_o.start_byte = start_q;
  assign cfg_o.end_byte   = end_q;
  assign cfg_o.last_pos   = eff_size - 8'd1;
  assign cfg_o.chk_pos    = eff_size - 8'd2;

endmodule

`default_nettype wire

// ----- design/fld_core.sv -----
// Framing state of the packet deframer: hunt, count, checksum and verdict.
// Depends on fld_pkg; computes the result for the current beat combinationally.
`default_nettype none

module fld_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      advance_i,
  input  wire logic [fld_pkg::ByteW-1:0] byte_i,
  input  fld_pkg::cfg_t                  cfg_i,
  output logic                           res_valid_o,
  output fld_pkg::res_t                  res_o,
  output fld_pkg::status_t               status_o
);

  logic                      in_packet_q, in_packet_d;
  logic [fld_pkg::ByteW-1:0] count_q, count_d;
  logic [fld_pkg::ByteW-1:0] sum_q, sum_d;
  logic                      matched_q, matched_d;
  logic                      is_last;

  assign is_last = in_packet_q && (count_q >= cfg_i.last_pos);

  assign res_valid_o       = in_packet_q || (byte_i == cfg_i.start_byte);
  assign res_o.byte_out    = byte_i;
  assign res_o.byte_index  = in_packet_q ? count_q : '0;
  assign res_o.last        = is_last;
  assign res_o.packet_good = is_last && matched_q && (byte_i == cfg_i.end_byte);

  always_comb begin
    in_packet_d = in_packet_q;
    count_d     = count_q;
    sum_d       = sum_q;
    matched_d   = matched_q;
    if (!in_packet_q) begin
      if (byte_i == cfg_i.start_byte) begin
        in_packet_d = 1'b1;
        count_d     = 8'd1;
        sum_d       = byte_i;
        matched_d   = 1'b0;
      end
    end else if (is_last) begin
      in_packet_d = 1'b0;
      count_d     = '0;
      sum_d       = '0;
      matched_d   = 1'b0;
    end else begin
      // The checksum byte itself is compared, not added.
      if (count_q == cfg_i.chk_pos) begin
        matched_d = (byte_i == sum_q);
      end else begin
        sum_d = sum_q + byte_i;
      end
      count_d = count_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      count_q     <= '0;
      sum_q       <= '0;
      matched_q   <= 1'b0;
    end else if (advance_i) begin
      in_packet_q <= in_packet_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      matched_q   <= matched_d;
    end
  end

  assign status_o.in_packet  = in_packet_q;
  assign status_o.byte_count = count_q;

endmodule

`default_nettype wire

// ----- design/fld_out.sv -----
// Result register of the packet deframer with valid/ready toward the sink.
// Depends on fld_pkg.
`default_nettype none

module fld_out (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  fld_pkg::res_t res_i,
  output logic          space_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output fld_pkg::res_t res_o
);

  logic          valid_q;
  fld_pkg::res_t res_q;

  // The register can take a new beat when empty or when it drains this cycle.
  assign space_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
